FILE: rtl/core/normalized_sq_distance_core_assert.svh
// assertion helpers for the distance core, clocked on clk and held off during rst
`ifndef NORMALIZED_SQ_DISTANCE_CORE_ASSERT_SVH
`define NORMALIZED_SQ_DISTANCE_CORE_ASSERT_SVH

// same-cycle implication
`define NSD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NSD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/nsd_pkg.sv
package nsd_pkg;

  localparam int COUNT_W  = 16;
  localparam int DIST_W   = 32;
  localparam int TOTAL_W  = 30;
  localparam int SUM_W    = 46;
  localparam int PROD_W   = 2 * TOTAL_W;
  localparam int TERM_W   = SUM_W + PROD_W;
  localparam int NUM_W    = TERM_W + 1;
  localparam int DEN_W    = 2 * PROD_W;
  // remainder doubles before compare, saturation check compares against 4 * den
  localparam int UNIT_W   = DEN_W + 3;
  localparam int STEP_W   = 7;

  localparam int DEFAULT_COUNT_BITS = 16;

  localparam logic [STEP_W-1:0] STEPS_MUL_SHORT = STEP_W'(TOTAL_W);
  localparam logic [STEP_W-1:0] STEPS_MUL_LONG  = STEP_W'(PROD_W);
  localparam logic [STEP_W-1:0] STEPS_DIV       = STEP_W'(DIST_W);
  localparam logic [STEP_W-1:0] STEPS_SINGLE    = STEP_W'(1);

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_ADD,
    OP_SUB
  } nsd_op_t;

  typedef struct packed {
    logic                start;
    nsd_op_t             op;
    logic [STEP_W-1:0]   steps;
    logic [UNIT_W-1:0]   a;
    logic [UNIT_W-1:0]   b;
  } nsd_cmd_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic                carry;
    logic [UNIT_W-1:0]   acc;
    logic [DIST_W-1:0]   quot;
  } nsd_stat_t;

endpackage

FILE: rtl/core/nsd_wide_unit.sv
// shared wide adder driven as shift-add multiplier, restoring divider or single add/sub
module nsd_wide_unit (
  input  logic              clk,
  input  logic              rst,
  input  nsd_pkg::nsd_cmd_t cmd,
  output nsd_pkg::nsd_stat_t stat
);

  localparam int W = nsd_pkg::UNIT_W;

  logic                       busy;
  logic                       done;
  logic [nsd_pkg::STEP_W-1:0] cnt;
  nsd_pkg::nsd_op_t           op;
  logic [W-1:0]               acc;
  logic [W-1:0]               opx;
  logic [W-1:0]               opy;
  logic                       carry;

  logic [W-1:0] a_in;
  logic [W-1:0] b_in;
  logic         sub;
  logic [W:0]   sum;

  always_comb begin
    unique case (op)
      nsd_pkg::OP_MUL: begin
        a_in = {acc[W-2:0], 1'b0};
        b_in = opy[W-1] ? opx : '0;
        sub  = 1'b0;
      end
      nsd_pkg::OP_DIV: begin
        // shift next dividend bit into the remainder
        a_in = {acc[W-2:0], opy[W-1]};
        b_in = opx;
        sub  = 1'b1;
      end
      nsd_pkg::OP_ADD: begin
        a_in = acc;
        b_in = opx;
        sub  = 1'b0;
      end
      nsd_pkg::OP_SUB: begin
        a_in = acc;
        b_in = opx;
        sub  = 1'b1;
      end
    endcase
    sum = {1'b0, a_in} + {1'b0, b_in ^ {W{sub}}} + (W+1)'(sub);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.steps;
      end else if (busy) begin
        if (cnt == nsd_pkg::STEPS_SINGLE) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - nsd_pkg::STEPS_SINGLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op <= cmd.op;
      unique case (cmd.op)
        nsd_pkg::OP_MUL: begin
          acc <= '0;
          opx <= cmd.a;
          opy <= cmd.b;
        end
        nsd_pkg::OP_DIV: begin
          // top of the dividend is already below the divisor
          acc <= cmd.a >> 2;
          opx <= cmd.b;
          opy <= cmd.a << (W - 2);
        end
        nsd_pkg::OP_ADD, nsd_pkg::OP_SUB: begin
          acc <= cmd.a;
          opx <= cmd.b;
          opy <= '0;
        end
      endcase
    end else if (busy) begin
      carry <= sum[W];
      unique case (op)
        nsd_pkg::OP_MUL: begin
          acc <= sum[W-1:0];
          opy <= {opy[W-2:0], 1'b0};
        end
        nsd_pkg::OP_DIV: begin
          acc <= sum[W] ? sum[W-1:0] : a_in;
          opy <= {opy[W-2:0], sum[W]};
        end
        nsd_pkg::OP_ADD, nsd_pkg::OP_SUB: begin
          acc <= sum[W-1:0];
        end
      endcase
    end
  end

  assign stat.busy  = busy;
  assign stat.done  = done;
  assign stat.carry = carry;
  assign stat.acc   = acc;
  assign stat.quot  = opy[nsd_pkg::DIST_W-1:0];

endmodule

FILE: rtl/core/normalized_sq_distance_core.sv
// Squared distance of two normalised count tables. Each word carries one count of either
// table; the core takes it in and steps through MAC_AA, MAC_AB and MAC_BB on it (one small
// multiplier forms a*a, a*b and b*b in turn) and takes no new pair until back in IDLE. On
// the word marked tlast the core runs the closing arithmetic on one shared 123-bit adder:
// three 30-step and four 60-step shift-add products, two subtracts, one add and a 32-step
// restoring division, during which s_tready stays low. A zero total skips that work and
// goes straight to the result with the flag set. The result word waits in an output
// register; the next table may start streaming while it is unclaimed.
module normalized_sq_distance_core #(
  parameter int COUNT_BITS = nsd_pkg::DEFAULT_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // first_count[15:0], second_count[31:16]
  input  logic        s_tlast,  // last_pair
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // distance[31:0]
  output logic        m_tuser   // zero_total
);

  localparam int TW = nsd_pkg::TOTAL_W;
  localparam int SW = nsd_pkg::SUM_W;
  localparam int UW = nsd_pkg::UNIT_W;

  typedef enum logic [3:0] {
    IDLE,
    MAC_AA,
    MAC_AB,
    MAC_BB,
    JOB_T1,
    JOB_T2,
    JOB_T3,
    JOB_P1,
    JOB_P2,
    JOB_M,
    JOB_D,
    JOB_SUM,
    JOB_NUM,
    JOB_SAT,
    JOB_DIV,
    FINISH
  } state_t;

  state_t state;
  logic   launch;

  logic [COUNT_BITS-1:0] cnt_a;
  logic [COUNT_BITS-1:0] cnt_b;
  logic                  last;

  logic [TW-1:0] s1;
  logic [TW-1:0] s2;
  logic [SW-1:0] saa;
  logic [SW-1:0] sab;
  logic [SW-1:0] sbb;

  logic [nsd_pkg::PROD_W-1:0] t1;
  logic [nsd_pkg::PROD_W-1:0] t2;
  logic [nsd_pkg::PROD_W-1:0] t3;
  logic [nsd_pkg::NUM_W-1:0]  p1;
  logic [nsd_pkg::TERM_W-1:0] p2;
  logic [nsd_pkg::TERM_W-1:0] m;
  logic [nsd_pkg::DEN_W-1:0]  d;
  logic [nsd_pkg::NUM_W-1:0]  n;

  logic [nsd_pkg::DIST_W-1:0] dist_hold;
  logic                       zero_hold;

  logic [COUNT_BITS-1:0]   mul_x;
  logic [COUNT_BITS-1:0]   mul_y;
  logic [2*COUNT_BITS-1:0] mul_p;

  nsd_pkg::nsd_cmd_t  cmd;
  nsd_pkg::nsd_stat_t stat;

  assign s_tready = (state == IDLE);

  // one small multiplier shared by the three pair products
  always_comb begin
    mul_x = (state == MAC_BB) ? cnt_b : cnt_a;
    mul_y = (state == MAC_AA) ? cnt_a : cnt_b;
    mul_p = mul_x * mul_y;
  end

  always_comb begin
    cmd.start = launch;
    cmd.op    = nsd_pkg::OP_MUL;
    cmd.steps = nsd_pkg::STEPS_MUL_SHORT;
    cmd.a     = '0;
    cmd.b     = '0;
    // multipliers go in left-justified, bit-serial from the top
    unique case (state)
      JOB_T1: begin
        cmd.a = UW'(s1);
        cmd.b = UW'(s1) << (UW - TW);
      end
      JOB_T2: begin
        cmd.a = UW'(s2);
        cmd.b = UW'(s2) << (UW - TW);
      end
      JOB_T3: begin
        cmd.a = UW'(s1);
        cmd.b = UW'(s2) << (UW - TW);
      end
      JOB_P1: begin
        cmd.steps = nsd_pkg::STEPS_MUL_LONG;
        cmd.a     = UW'(saa);
        cmd.b     = UW'(t2) << (UW - nsd_pkg::PROD_W);
      end
      JOB_P2: begin
        cmd.steps = nsd_pkg::STEPS_MUL_LONG;
        cmd.a     = UW'(sbb);
        cmd.b     = UW'(t1) << (UW - nsd_pkg::PROD_W);
      end
      JOB_M: begin
        cmd.steps = nsd_pkg::STEPS_MUL_LONG;
        cmd.a     = UW'(sab);
        cmd.b     = UW'(t3) << (UW - nsd_pkg::PROD_W);
      end
      JOB_D: begin
        cmd.steps = nsd_pkg::STEPS_MUL_LONG;
        cmd.a     = UW'(t1);
        cmd.b     = UW'(t2) << (UW - nsd_pkg::PROD_W);
      end
      JOB_SUM: begin
        cmd.op    = nsd_pkg::OP_ADD;
        cmd.steps = nsd_pkg::STEPS_SINGLE;
        cmd.a     = UW'(p1);
        cmd.b     = UW'(p2);
      end
      JOB_NUM: begin
        cmd.op    = nsd_pkg::OP_SUB;
        cmd.steps = nsd_pkg::STEPS_SINGLE;
        cmd.a     = UW'(p1);
        cmd.b     = UW'(m) << 1;
      end
      JOB_SAT: begin
        // quotient overflows 32 bits exactly when num >= 4 * den
        cmd.op    = nsd_pkg::OP_SUB;
        cmd.steps = nsd_pkg::STEPS_SINGLE;
        cmd.a     = UW'(n);
        cmd.b     = UW'(d) << 2;
      end
      JOB_DIV: begin
        cmd.op    = nsd_pkg::OP_DIV;
        cmd.steps = nsd_pkg::STEPS_DIV;
        cmd.a     = UW'(n);
        cmd.b     = UW'(d);
      end
      default: begin
        cmd.op = nsd_pkg::OP_MUL;
      end
    endcase
  end

  nsd_wide_unit u_unit (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      launch   <= 1'b0;
      m_tvalid <= 1'b0;
      s1       <= '0;
      s2       <= '0;
      saa      <= '0;
      sab      <= '0;
      sbb      <= '0;
    end else begin
      launch <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_tvalid) begin
            cnt_a <= s_tdata[COUNT_BITS-1:0];
            cnt_b <= s_tdata[nsd_pkg::COUNT_W+COUNT_BITS-1:nsd_pkg::COUNT_W];
            last  <= s_tlast;
            state <= MAC_AA;
          end
        end
        MAC_AA: begin
          s1    <= s1 + TW'(cnt_a);
          s2    <= s2 + TW'(cnt_b);
          saa   <= saa + SW'(mul_p);
          state <= MAC_AB;
        end
        MAC_AB: begin
          sab   <= sab + SW'(mul_p);
          state <= MAC_BB;
        end
        MAC_BB: begin
          sbb <= sbb + SW'(mul_p);
          if (!last) begin
            state <= IDLE;
          end else if (s1 == '0 || s2 == '0) begin
            dist_hold <= '0;
            zero_hold <= 1'b1;
            state     <= FINISH;
          end else begin
            zero_hold <= 1'b0;
            launch    <= 1'b1;
            state     <= JOB_T1;
          end
        end
        JOB_T1: begin
          if (stat.done) begin
            t1     <= stat.acc[nsd_pkg::PROD_W-1:0];
            launch <= 1'b1;
            state  <= JOB_T2;
          end
        end
        JOB_T2: begin
          if (stat.done) begin
            t2     <= stat.acc[nsd_pkg::PROD_W-1:0];
            launch <= 1'b1;
            state  <= JOB_T3;
          end
        end
        JOB_T3: begin
          if (stat.done) begin
            t3     <= stat.acc[nsd_pkg::PROD_W-1:0];
            launch <= 1'b1;
            state  <= JOB_P1;
          end
        end
        JOB_P1: begin
          if (stat.done) begin
            p1     <= stat.acc[nsd_pkg::NUM_W-1:0];
            launch <= 1'b1;
            state  <= JOB_P2;
          end
        end
        JOB_P2: begin
          if (stat.done) begin
            p2     <= stat.acc[nsd_pkg::TERM_W-1:0];
            launch <= 1'b1;
            state  <= JOB_M;
          end
        end
        JOB_M: begin
          if (stat.done) begin
            m      <= stat.acc[nsd_pkg::TERM_W-1:0];
            launch <= 1'b1;
            state  <= JOB_D;
          end
        end
        JOB_D: begin
          if (stat.done) begin
            d      <= stat.acc[nsd_pkg::DEN_W-1:0];
            launch <= 1'b1;
            state  <= JOB_SUM;
          end
        end
        JOB_SUM: begin
          if (stat.done) begin
            p1     <= stat.acc[nsd_pkg::NUM_W-1:0];
            launch <= 1'b1;
            state  <= JOB_NUM;
          end
        end
        JOB_NUM: begin
          if (stat.done) begin
            if (!stat.carry) begin
              // negative numerator after a wrap reads as zero
              dist_hold <= '0;
              state     <= FINISH;
            end else begin
              n      <= stat.acc[nsd_pkg::NUM_W-1:0];
              launch <= 1'b1;
              state  <= JOB_SAT;
            end
          end
        end
        JOB_SAT: begin
          if (stat.done) begin
            if (stat.carry) begin
              dist_hold <= '1;
              state     <= FINISH;
            end else begin
              launch <= 1'b1;
              state  <= JOB_DIV;
            end
          end
        end
        JOB_DIV: begin
          if (stat.done) begin
            dist_hold <= stat.quot;
            state     <= FINISH;
          end
        end
        FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= dist_hold;
            m_tuser  <= zero_hold;
            s1       <= '0;
            s2       <= '0;
            saa      <= '0;
            sab      <= '0;
            sbb      <= '0;
            state    <= IDLE;
          end
        end
      endcase
    end
  end

`include "normalized_sq_distance_core_assert.svh"

  `NSD_ASSERT_IMP(a_ready_unit_idle, s_tready, !stat.busy, "word taken while unit busy")
  `NSD_ASSERT_NXT(a_accept_holds_off, s_tvalid && s_tready, !s_tready, "back-to-back accept")
  `NSD_ASSERT_NXT(a_start_busy, cmd.start, stat.busy, "unit ignored start")
  `NSD_ASSERT_IMP(a_zero_flag_dist, m_tvalid && m_tuser, m_tdata == '0, "zero total with distance")

endmodule

FILE: verif/normalized_sq_distance_core_tb.sv
module normalized_sq_distance_core_tb;

  localparam int CW = nsd_pkg::COUNT_W;
  localparam int DW = nsd_pkg::DIST_W;
  localparam int RANDOM_PAIRS = 1600;
  localparam int TAIL_CYCLES = 500;

  typedef struct {
    logic [CW-1:0] first_count;
    logic [CW-1:0] second_count;
    logic          last_pair;
    bit            drain;  // hold this word back until every result is in
    bit            calm;   // no idling from here on
  } pair_word_t;

  typedef struct {
    logic [DW-1:0] distance;
    logic          zero_total;
  } dist_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // first_count[15:0], second_count[31:16]
  logic        s_tlast = 1'b0; // last_pair
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // distance[31:0]
  logic        m_tuser;        // zero_total

  pair_word_t   pending_q[$];
  dist_result_t expected_dist_q[$];
  pair_word_t   cur_word;

  // running sums of the table pair under way
  logic [29:0] sum_first, sum_second;
  logic [45:0] sq_first, sq_cross, sq_second;

  int     src_gap = 0;
  int     sink_gap = 0;
  bit     quiet_phase = 1'b0;
  int     error_count = 0;
  longint cycle_count = 0;
  longint cycle_limit = 64'd100_000_000;

  normalized_sq_distance_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // floor(N * 2^30 / (s1^2 s2^2)), exact in 256 bits
  function automatic logic [DW-1:0] sq_distance_q30(input logic [29:0] t1, input logic [29:0] t2,
                                                    input logic [45:0] qa, input logic [45:0] qx,
                                                    input logic [45:0] qb);
    logic [255:0] w1, w2, wa, wx, wb, plus, minus, quo;
    w1 = t1;
    w2 = t2;
    wa = qa;
    wx = qx;
    wb = qb;
    plus = wa * w2 * w2 + wb * w1 * w1;
    minus = (wx * w1 * w2) << 1;
    // a wrapped stream can give a negative numerator
    if (plus <= minus) return '0;
    quo = ((plus - minus) << 30) / (w1 * w1 * w2 * w2);
    if (quo > 256'hFFFF_FFFF) return '1;
    return quo[DW-1:0];
  endfunction

  task automatic fold_pair(input pair_word_t w);
    logic [31:0] a, b;
    dist_result_t r;
    a = w.first_count;
    b = w.second_count;
    sum_first = sum_first + a[29:0];
    sum_second = sum_second + b[29:0];
    sq_first = sq_first + 46'(a * a);
    sq_cross = sq_cross + 46'(a * b);
    sq_second = sq_second + 46'(b * b);
    if (w.last_pair) begin
      if (sum_first == 0 || sum_second == 0) begin
        r.distance = '0;
        r.zero_total = 1'b1;
      end else begin
        r.distance = sq_distance_q30(sum_first, sum_second, sq_first, sq_cross, sq_second);
        r.zero_total = 1'b0;
      end
      expected_dist_q.insert(expected_dist_q.size(), r);
      sum_first = '0;
      sum_second = '0;
      sq_first = '0;
      sq_cross = '0;
      sq_second = '0;
    end
  endtask

  task automatic push_pair(input int a, input int b, input bit last, input bit drain,
                           input bit calm);
    pair_word_t w;
    w.first_count = a[CW-1:0];
    w.second_count = b[CW-1:0];
    w.last_pair = last;
    w.drain = drain;
    w.calm = calm;
    pending_q.insert(pending_q.size(), w);
  endtask

  function automatic int count_value(input int mode);
    case (mode)
      0: return $urandom_range(0, 65535);
      1: return $urandom_range(0, 15);
      2: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : 0;
      3: return $urandom_range(16'hF000, 16'hFFFF);
      default: return 0;
    endcase
  endfunction

  task automatic add_table(input int len, input bit drain, input bit calm);
    int ma, mb, zero_side, a, b;
    ma = $urandom_range(0, 3);
    mb = $urandom_range(0, 3);
    zero_side = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 2) : 0;
    for (int i = 0; i < len; i++) begin
      a = (zero_side == 1) ? 0 : count_value(ma);
      b = (zero_side == 2) ? 0 : count_value(mb);
      push_pair(a, b, i == len - 1, drain && i == 0, calm);
    end
  endtask

  // source side
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tlast <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) fold_pair(cur_word);
      if (src_gap != 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_q.size() == 0 ||
                   (pending_q[0].drain && expected_dist_q.size() != 0)) begin
        s_tvalid <= 1'b0;
      end else begin
        cur_word = pending_q.pop_front();
        if (cur_word.calm) quiet_phase = 1'b1;
        s_tdata <= {cur_word.second_count, cur_word.first_count};
        s_tlast <= cur_word.last_pair;
        s_tvalid <= 1'b1;
        if (!cur_word.calm && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 15);
      end
    end
  end

  // result side
  always @(posedge clk) begin
    dist_result_t exp_r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_dist_q.size() == 0) begin
          $error("unexpected result word: distance %h zero_total %b", m_tdata, m_tuser);
          error_count++;
        end else begin
          exp_r = expected_dist_q.pop_front();
          if (m_tdata !== exp_r.distance) begin
            $error("distance: expected %h, actual %h", exp_r.distance, m_tdata);
            error_count++;
          end
          if (m_tuser !== exp_r.zero_total) begin
            $error("zero_total: expected %b, actual %b", exp_r.zero_total, m_tuser);
            error_count++;
          end
        end
      end
      if (sink_gap != 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 11) == 0) begin
        sink_gap = $urandom_range(0, 14);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int random_pairs, len;
    bit drained;
    longint budget;
    sum_first = '0;
    sum_second = '0;
    sq_first = '0;
    sq_cross = '0;
    sq_second = '0;

    // zero totals: both, first only, second only
    push_pair(0, 0, 1, 0, 0);
    push_pair(0, 5, 1, 0, 0);
    push_pair(7, 0, 1, 0, 0);
    // identical tables give zero distance
    push_pair(16'hFFFF, 16'hFFFF, 1, 0, 0);
    // disjoint tables give the largest distance, 2.0
    push_pair(16'hFFFF, 0, 0, 0, 0);
    push_pair(0, 16'hFFFF, 1, 0, 0);
    push_pair(3, 1, 0, 0, 0);
    push_pair(1, 3, 1, 0, 0);
    push_pair(16'hFFFF, 1, 0, 0, 0);
    push_pair(1, 16'hFFFF, 1, 0, 0);
    push_pair(5, 5, 0, 0, 0);
    push_pair(10, 20, 0, 0, 0);
    push_pair(16'hAAAA, 16'h5555, 0, 0, 0);
    push_pair(16'h5555, 16'hAAAA, 0, 0, 0);
    push_pair(0, 0, 1, 0, 0);

    random_pairs = 0;
    drained = 1'b0;
    while (random_pairs < RANDOM_PAIRS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 120) : $urandom_range(1, 12);
      add_table(len, !drained && random_pairs >= RANDOM_PAIRS / 2,
                random_pairs >= RANDOM_PAIRS * 9 / 10);
      if (random_pairs >= RANDOM_PAIRS / 2) drained = 1'b1;
      random_pairs += len;
    end

    // worst case per word: own cycles, longest gap, and the closing arithmetic plus a stall
    budget = 11 + TAIL_CYCLES;
    foreach (pending_q[i]) budget += 20 + (pending_q[i].last_pair ? 450 : 0);
    cycle_limit = budget * 4;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (pending_q.size() != 0 || s_tvalid || expected_dist_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_dist_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
